// File: design/ipc_pkg.sv
package ipc_pkg;

    // Datapath width and fixed-point format (signed Q16.16)
    localparam int W         = 32;
    localparam int FRAC_BITS = 16;

    // Width of the gain * difference products and of the accumulator
    localparam int PROD_W = 2 * W + 2;
    localparam int ACC_W  = 2 * W + 4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX    = 3'd4;

    // Range limits of a W-bit signed value
    localparam logic signed [W-1:0] W_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] W_MIN = {1'b1, {(W-1){1'b0}}};

    // Error differences for the three terms
    typedef struct packed {
        logic signed [W:0]   p_diff;   // e - e1
        logic signed [W:0]   i_sum;    // e + e1
        logic signed [W+1:0] d_diff;   // e - 2*e1 + e2
        logic signed [W-1:0] meas;
    } err_stage_t;

    // Exact products
    typedef struct packed {
        logic signed [PROD_W-1:0] p;
        logic signed [PROD_W-1:0] i;
        logic signed [PROD_W-1:0] d;
        logic signed [W-1:0]      meas;
    } prod_stage_t;

    // Saturated sum with overflow flag
    typedef struct packed {
        logic signed [W-1:0] value;
        logic                hit;
    } sat_stage_t;

endpackage

// File: design/incremental_pid_clamped_core.sv
// Incremental (velocity form) PID controller with clamped output.
// Input stream: one request per control sample, tdata = {measured, target},
// both signed Q16.16, target in the low 32 bits. Output stream: one result
// per request, tdata = drive (signed Q16.16), tuser[0] = clamped, set when
// the sum saturated to 32 bits or was forced to out_min / out_max.
// Config port: cfg_wen writes cfg_wdata to register cfg_index at the clock
// edge (0 prop_gain, 1 integ_gain, 2 deriv_gain, 3 out_min, 4 out_max);
// other indexes are ignored. Write only while no request is in flight.
// Each accepted request passes in order through the input register,
// error/difference, multiply, partial sum, saturate and clamp/output
// registers. Throughput: one request per cycle while the output is not
// stalled; the error history is updated in the single difference stage.
// Each stage has its own valid bit and holds when the next one is full, so
// a stalled receiver backs up the pipeline one stage at a time and input
// is still taken while empty stages remain.
// Reset: gains 0, limits at the full signed range, error history 0, all
// pipeline stages empty.
module incremental_pid_clamped_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [2*ipc_pkg::W-1:0]         s_axis_tdata,   // [31:0] target, [63:32] measured
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [ipc_pkg::W-1:0]           m_axis_tdata,   // [31:0] drive
    output logic [0:0]                      m_axis_tuser,   // [0] clamped
    input  logic                            cfg_wen,
    input  logic [ipc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ipc_pkg::W-1:0]           cfg_wdata
);
    import ipc_pkg::*;

    logic signed [W-1:0] prop_gain_reg;
    logic signed [W-1:0] integ_gain_reg;
    logic signed [W-1:0] deriv_gain_reg;
    logic signed [W-1:0] out_min_reg;
    logic signed [W-1:0] out_max_reg;

    logic        err_valid;
    logic        err_ready;
    err_stage_t  err_data;
    logic        prod_valid;
    logic        prod_ready;
    prod_stage_t prod_data;
    logic        sat_valid;
    logic        sat_ready;
    sat_stage_t  sat_data;
    logic signed [W-1:0] drive;
    logic        clamped;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg  <= '0;
            integ_gain_reg <= '0;
            deriv_gain_reg <= '0;
            out_min_reg    <= W_MIN;
            out_max_reg    <= W_MAX;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_PROP_GAIN:  prop_gain_reg  <= cfg_wdata;
                REG_INTEG_GAIN: integ_gain_reg <= cfg_wdata;
                REG_DERIV_GAIN: deriv_gain_reg <= cfg_wdata;
                REG_OUT_MIN:    out_min_reg    <= cfg_wdata;
                REG_OUT_MAX:    out_max_reg    <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // Input register, saturated error and differences
    ipc_err_stage u_err (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .target    (s_axis_tdata[W-1:0]),
        .measured  (s_axis_tdata[2*W-1:W]),
        .out_valid (err_valid),
        .out_ready (err_ready),
        .out_data  (err_data)
    );

    // Gain products
    ipc_mult_stage u_mult (
        .clk        (clk),
        .rst_n      (rst_n),
        .prop_gain  (prop_gain_reg),
        .integ_gain (integ_gain_reg),
        .deriv_gain (deriv_gain_reg),
        .in_valid   (err_valid),
        .in_ready   (err_ready),
        .in_data    (err_data),
        .out_valid  (prod_valid),
        .out_ready  (prod_ready),
        .out_data   (prod_data)
    );

    // Scale, accumulate, saturate
    ipc_sum_stage u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_data   (prod_data),
        .out_valid (sat_valid),
        .out_ready (sat_ready),
        .out_data  (sat_data)
    );

    // Limit clamp and output register
    ipc_clamp_stage u_clamp (
        .clk       (clk),
        .rst_n     (rst_n),
        .out_min   (out_min_reg),
        .out_max   (out_max_reg),
        .in_valid  (sat_valid),
        .in_ready  (sat_ready),
        .in_data   (sat_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .drive     (drive),
        .clamped   (clamped)
    );

    assign m_axis_tdata = drive;
    assign m_axis_tuser = clamped;

    // An empty output register means the whole pipeline can take input
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

    // A saturated sum sits exactly at a range limit
    assert property (@(posedge clk) disable iff (!rst_n)
        sat_valid && sat_data.hit |-> sat_data.value == W_MAX || sat_data.value == W_MIN)
    else $error("saturation flag without limit value");

    // A new result only follows a filled saturation stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(sat_valid))
    else $error("result appeared without upstream data");

endmodule

// File: design/ipc_err_stage.sv
module ipc_err_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [ipc_pkg::W-1:0] target,
    input  logic signed [ipc_pkg::W-1:0] measured,
    output logic                        out_valid,
    input  logic                        out_ready,
    output ipc_pkg::err_stage_t         out_data
);
    import ipc_pkg::*;

    logic                s0_valid_reg;
    logic signed [W-1:0] tgt_reg;
    logic signed [W-1:0] meas_reg;
    logic                s1_ready;
    logic                s1_valid_reg;
    err_stage_t          s1_data_reg;
    err_stage_t          s1_data_next;
    logic signed [W-1:0] prev_err_reg;
    logic signed [W-1:0] prev_prev_err_reg;
    logic signed [W:0]   diff_wide;
    logic signed [W-1:0] err;
    logic                s1_load;

    assign s1_ready = !s1_valid_reg || out_ready;
    assign in_ready = !s0_valid_reg || s1_ready;
    assign s1_load  = s0_valid_reg && s1_ready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            tgt_reg  <= target;
            meas_reg <= measured;
        end
    end

    // Saturated error
    always_comb
    begin
        diff_wide = {tgt_reg[W-1], tgt_reg} - {meas_reg[W-1], meas_reg};
        if (diff_wide[W] != diff_wide[W-1])
        begin
            err = diff_wide[W] ? W_MIN : W_MAX;
        end
        else
        begin
            err = diff_wide[W-1:0];
        end
    end

    // Differences against the error history
    always_comb
    begin
        s1_data_next.p_diff = {err[W-1], err} - {prev_err_reg[W-1], prev_err_reg};
        s1_data_next.i_sum  = {err[W-1], err} + {prev_err_reg[W-1], prev_err_reg};
        s1_data_next.d_diff = {{2{err[W-1]}}, err}
                            - {prev_err_reg[W-1], prev_err_reg, 1'b0}
                            + {{2{prev_prev_err_reg[W-1]}}, prev_prev_err_reg};
        s1_data_next.meas   = meas_reg;
    end

    // Difference register and history shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            prev_err_reg      <= '0;
            prev_prev_err_reg <= '0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
            if (s1_load)
            begin
                prev_prev_err_reg <= prev_err_reg;
                prev_err_reg      <= err;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_data_reg <= s1_data_next;
        end
    end

    assign out_valid = s1_valid_reg;
    assign out_data  = s1_data_reg;

endmodule

// File: design/ipc_mult_stage.sv
module ipc_mult_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic signed [ipc_pkg::W-1:0] prop_gain,
    input  logic signed [ipc_pkg::W-1:0] integ_gain,
    input  logic signed [ipc_pkg::W-1:0] deriv_gain,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  ipc_pkg::err_stage_t         in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output ipc_pkg::prod_stage_t        out_data
);
    import ipc_pkg::*;

    logic        valid_reg;
    prod_stage_t data_reg;
    prod_stage_t data_next;

    assign in_ready = !valid_reg || out_ready;

    // Three parallel products, exact
    always_comb
    begin
        data_next.p    = prop_gain * in_data.p_diff;
        data_next.i    = integ_gain * in_data.i_sum;
        data_next.d    = deriv_gain * in_data.d_diff;
        data_next.meas = in_data.meas;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: design/ipc_sum_stage.sv
module ipc_sum_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  ipc_pkg::prod_stage_t   in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output ipc_pkg::sat_stage_t    out_data
);
    import ipc_pkg::*;

    logic                    part_valid_reg;
    logic signed [ACC_W-1:0] pi_reg;
    logic signed [ACC_W-1:0] dm_reg;
    logic signed [ACC_W-1:0] pi_next;
    logic signed [ACC_W-1:0] dm_next;
    logic signed [PROD_W-1:0] p_sh;
    logic signed [PROD_W-1:0] i_sh;
    logic signed [PROD_W-1:0] d_sh;
    logic                    part_ready;
    logic                    sat_valid_reg;
    sat_stage_t              sat_reg;
    sat_stage_t              sat_next;
    logic signed [ACC_W-1:0] total;

    assign part_ready = !sat_valid_reg || out_ready;
    assign in_ready   = !part_valid_reg || part_ready;

    // Scale products (floor) and form two partial sums
    always_comb
    begin
        p_sh    = in_data.p >>> FRAC_BITS;
        i_sh    = in_data.i >>> (FRAC_BITS + 1);
        d_sh    = in_data.d >>> FRAC_BITS;
        pi_next = ACC_W'(p_sh) + ACC_W'(i_sh);
        dm_next = ACC_W'(d_sh) + ACC_W'(in_data.meas);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            part_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pi_reg <= pi_next;
            dm_reg <= dm_next;
        end
    end

    // Final sum and saturation to W bits
    always_comb
    begin
        total = pi_reg + dm_reg;
        priority if (total > ACC_W'(W_MAX))
        begin
            sat_next.value = W_MAX;
            sat_next.hit   = 1'b1;
        end
        else if (total < ACC_W'(W_MIN))
        begin
            sat_next.value = W_MIN;
            sat_next.hit   = 1'b1;
        end
        else
        begin
            sat_next.value = total[W-1:0];
            sat_next.hit   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_valid_reg <= 1'b0;
        end
        else if (part_ready)
        begin
            sat_valid_reg <= part_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (part_valid_reg && part_ready)
        begin
            sat_reg <= sat_next;
        end
    end

    assign out_valid = sat_valid_reg;
    assign out_data  = sat_reg;

endmodule

// File: design/ipc_clamp_stage.sv
module ipc_clamp_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic signed [ipc_pkg::W-1:0] out_min,
    input  logic signed [ipc_pkg::W-1:0] out_max,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  ipc_pkg::sat_stage_t         in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [ipc_pkg::W-1:0] drive,
    output logic                        clamped
);
    import ipc_pkg::*;

    logic                valid_reg;
    logic signed [W-1:0] drive_reg;
    logic signed [W-1:0] drive_next;
    logic                clamped_reg;
    logic                clamped_next;

    assign in_ready = !valid_reg || out_ready;

    // The lower-limit check comes first: when the limits cross, values below out_min give out_min, all others out_max
    always_comb
    begin
        priority if (in_data.value < out_min)
        begin
            drive_next   = out_min;
            clamped_next = 1'b1;
        end
        else if (in_data.value > out_max)
        begin
            drive_next   = out_max;
            clamped_next = 1'b1;
        end
        else
        begin
            drive_next   = in_data.value;
            clamped_next = in_data.hit;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            drive_reg   <= drive_next;
            clamped_reg <= clamped_next;
        end
    end

    assign out_valid = valid_reg;
    assign drive     = drive_reg;
    assign clamped   = clamped_reg;

endmodule
